FILE: rtl/sfa_pkg.sv
`timescale 1ns / 1ps
package sfa_pkg;
	localparam int unsigned WordW = 32;
	localparam int unsigned ExpW  = 8;
	localparam int unsigned MantW = 23;
	localparam int unsigned SigW  = MantW + 1;
	localparam int unsigned LzW   = 5;

	// Alignment result handed from stage 1 to stage 2.
	typedef struct packed {
		logic              bypass;
		logic [WordW-1:0]  bypass_word;
		logic              sign_a;
		logic              sign_b;
		logic [ExpW-1:0]   exp;
		logic [SigW-1:0]   sig_a;
		logic [SigW-1:0]   sig_b;
	} align_t;

	// Add/subtract result handed from stage 2 to stage 3.
	typedef struct packed {
		logic              bypass;
		logic [WordW-1:0]  bypass_word;
		logic              sign;
		logic [ExpW-1:0]   exp;
		logic [SigW-1:0]   sig;
		logic              zero;
	} addsub_t;

	// Count leading zeros of a 24-bit significand (nonzero input).
	function automatic logic [LzW-1:0] lead_zeros(input logic [SigW-1:0] v);
		logic [LzW-1:0] n;
		logic           found;
		n = '0;
		found = 1'b0;
		for (int i = SigW - 1; i >= 0; i--) begin
			if (!found && v[i]) begin
				n = LzW'(SigW - 1 - i);
				found = 1'b1;
			end
		end
		return n;
	endfunction
endpackage

FILE: rtl/single_float_adder.sv
`timescale 1ns / 1ps
// A start strobe advances through valid registers vld_s1, vld_s2 and vld_s3 to the done strobe.
// Throughput: one transaction per cycle; busy stays low, the pipeline
// has no stall since the receiver cannot hold results off.
// Stages: align, add/subtract, normalize and pack.
// Reset clears the valid bits only; payload registers are not reset.
module single_float_adder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [31:0] operand_a,
	input  logic [31:0] operand_b,
	output logic        done,
	output logic [31:0] sum_bits
);
	sfa_pkg::align_t  align_c, align_s1;
	sfa_pkg::addsub_t addsub_c, addsub_s2;
	logic [31:0]      sum_c, sum_s3;
	logic             vld_s1, vld_s2, vld_s3;

	assign busy = 1'b0;

	sfa_align  u_align  (.operand_a(operand_a), .operand_b(operand_b), .aligned(align_c));
	sfa_addsub u_addsub (.aligned(align_s1), .result(addsub_c));
	sfa_norm   u_norm   (.result(addsub_s2), .sum_word(sum_c));

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	// Advance payload
	always_ff @(posedge clk) begin
		align_s1  <= align_c;
		addsub_s2 <= addsub_c;
		sum_s3    <= sum_c;
	end

	assign done = vld_s3;
	assign sum_bits = sum_s3;
endmodule

FILE: rtl/sfa_align.sv
`timescale 1ns / 1ps
module sfa_align (
	input  logic [sfa_pkg::WordW-1:0] operand_a,
	input  logic [sfa_pkg::WordW-1:0] operand_b,
	output sfa_pkg::align_t           aligned
);
	logic [sfa_pkg::ExpW-1:0] ea, eb, shift_amt;
	logic                     a_small;
	logic [sfa_pkg::SigW-1:0] ma, mb;

	// Unpack, pick the larger exponent, shift the other significand; a zero operand bypasses the other
	always_comb begin
		ea = operand_a[sfa_pkg::WordW-2 -: sfa_pkg::ExpW];
		eb = operand_b[sfa_pkg::WordW-2 -: sfa_pkg::ExpW];
		ma = {1'b1, operand_a[sfa_pkg::MantW-1:0]};
		mb = {1'b1, operand_b[sfa_pkg::MantW-1:0]};
		a_small = ea < eb;
		shift_amt = a_small ? eb - ea : ea - eb;
		aligned.sign_a = operand_a[sfa_pkg::WordW-1];
		aligned.sign_b = operand_b[sfa_pkg::WordW-1];
		aligned.exp = a_small ? eb : ea;
		aligned.sig_a = ma;
		aligned.sig_b = mb;
		// shifts of 24 or more already give zero on a 24-bit significand
		if (a_small) begin
			aligned.sig_a = (shift_amt >= 8'd32) ? '0 : ma >> shift_amt;
		end else begin
			aligned.sig_b = (shift_amt >= 8'd32) ? '0 : mb >> shift_amt;
		end
		aligned.bypass = 1'b0;
		aligned.bypass_word = '0;
		if (operand_a[sfa_pkg::WordW-2:0] == '0) begin
			aligned.bypass = 1'b1;
			aligned.bypass_word = operand_b;
		end else if (operand_b[sfa_pkg::WordW-2:0] == '0) begin
			aligned.bypass = 1'b1;
			aligned.bypass_word = operand_a;
		end
	end
endmodule

FILE: rtl/sfa_addsub.sv
`timescale 1ns / 1ps
module sfa_addsub (
	input  sfa_pkg::align_t  aligned,
	output sfa_pkg::addsub_t result
);
	logic [sfa_pkg::SigW:0] total;

	// Add on equal signs, else subtract smaller from larger
	always_comb begin
		result.bypass = aligned.bypass;
		result.bypass_word = aligned.bypass_word;
		result.exp = aligned.exp;
		result.zero = 1'b0;
		total = '0;
		if (aligned.sign_a == aligned.sign_b) begin
			result.sign = aligned.sign_a;
			total = {1'b0, aligned.sig_a} + {1'b0, aligned.sig_b};
			if (total[sfa_pkg::SigW]) begin
				result.sig = total[sfa_pkg::SigW:1];
				result.exp = aligned.exp + 8'd1;
			end else begin
				result.sig = total[sfa_pkg::SigW-1:0];
			end
		end else if (aligned.sig_a > aligned.sig_b) begin
			result.sign = aligned.sign_a;
			result.sig = aligned.sig_a - aligned.sig_b;
		end else begin
			result.sign = aligned.sign_b;
			result.sig = aligned.sig_b - aligned.sig_a;
			result.zero = (aligned.sig_a == aligned.sig_b);
		end
	end
endmodule

FILE: rtl/sfa_norm.sv
`timescale 1ns / 1ps
module sfa_norm (
	input  sfa_pkg::addsub_t          result,
	output logic [sfa_pkg::WordW-1:0] sum_word
);
	logic [sfa_pkg::LzW-1:0]  lz;
	logic [sfa_pkg::SigW-1:0] sig;

	// Left-normalize and pack, or pass the bypass word or a zero result
	always_comb begin
		lz = sfa_pkg::lead_zeros(result.sig);
		sig = result.sig << lz;
		if (result.bypass) begin
			sum_word = result.bypass_word;
		end else if (result.zero) begin
			sum_word = '0;
		end else begin
			sum_word = {result.sign, result.exp - {3'b000, lz},
				sig[sfa_pkg::MantW-1:0]};
		end
	end
endmodule
